// ===== hw/rtl/fsf_pkg.sv =====
// ----------------------------------------------------------------------------
// fsf_pkg: shared widths, register indexes and types
// Fixed-point widths for the Frenet start frame datapath and its unit-vector
// normalizer. All widths follow from FRAC_BITS and the field widths.
// ----------------------------------------------------------------------------
package fsf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int CFG_W     = 18;
    localparam int OUT_W     = 18;
    localparam int CFG_IDX_W = 2;

    localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
    localparam int OUT_MIN = -(2 ** (OUT_W - 1));

    // radius * trig products and their rounded form
    localparam int PROD_W = IN_W + CFG_W;
    localparam int PT_A   = IN_W + CFG_W - FRAC_BITS;
    localparam int PT_W   = (PT_A > IN_W + 1) ? PT_A : IN_W + 1;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    // difference vectors
    localparam int VEC_W = PT_W + 3;
    localparam int SH_W  = $clog2(VEC_W);

    // the largest normalized magnitude of a nonzero vector lies in [2^(NRM_W-1), 2^NRM_W)
    localparam int NRM_W  = 30;
    localparam int SQ_W   = 2 * NRM_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    // divider
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int NUM_W = NRM_W + FRAC_BITS + 1;
    localparam int SAT_W = ((Q_W > OUT_W) ? Q_W : OUT_W) + 2;

    // cross product
    localparam int XP_W = 2 * OUT_W;
    localparam int XD_W = XP_W + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COS_ONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_ONE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_TWO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_TWO = 2'd3;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [OUT_W-1:0] t_unit;

    typedef struct packed {
        logic                   zero;
        logic [2:0]             neg;
        logic [2:0][NRM_W-1:0]  mag;
    } t_norm_side;

endpackage

// ===== hw/rtl/fsf_unit3.sv =====
// ----------------------------------------------------------------------------
// fsf_unit3: pipelined unit-vector normalizer
// Abs, block normalize, sum of squares, bit-per-stage square root and
// bit-per-stage restoring division, then sign restore and saturation.
// ----------------------------------------------------------------------------
module fsf_unit3
    import fsf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_vec  i_vec [3],
    output logic  o_valid,
    output t_unit o_unit [3],
    output logic  o_zero
);

    // stage A: magnitudes
    logic             r_a_vld;
    logic [VEC_W-1:0] r_a_mag [3];
    logic [2:0]       r_a_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else          r_a_vld <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a_neg[i] <= i_vec[i][VEC_W-1];
            r_a_mag[i] <= i_vec[i][VEC_W-1] ? $unsigned(-i_vec[i]) : $unsigned(i_vec[i]);
        end
    end

    // stage B: largest magnitude
    logic             r_b_vld;
    logic [VEC_W-1:0] r_b_max;
    logic [VEC_W-1:0] r_b_mag [3];
    logic [2:0]       r_b_neg;
    logic [VEC_W-1:0] n_max;

    always_comb begin
        n_max = r_a_mag[0];
        if (r_a_mag[1] > n_max) n_max = r_a_mag[1];
        if (r_a_mag[2] > n_max) n_max = r_a_mag[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_vld <= 1'b0;
        else          r_b_vld <= r_a_vld;
    end

    always_ff @(posedge i_clk) begin
        r_b_max <= n_max;
        r_b_mag <= r_a_mag;
        r_b_neg <= r_a_neg;
    end

    // stage C: leading one and shift amounts
    logic             r_c_vld;
    logic [SH_W-1:0]  r_c_rs;
    logic [SH_W-1:0]  r_c_ls;
    logic             r_c_zero;
    logic [VEC_W-1:0] r_c_mag [3];
    logic [2:0]       r_c_neg;
    logic [SH_W-1:0]  n_pos;
    logic [SH_W-1:0]  n_rs;
    logic [SH_W-1:0]  n_ls;

    always_comb begin
        n_pos = '0;
        for (int i = 0; i < VEC_W; i++) begin
            if (r_b_max[i]) n_pos = SH_W'(i);
        end
        if (n_pos > SH_W'(NRM_W - 1)) begin
            n_rs = n_pos - SH_W'(NRM_W - 1);
            n_ls = '0;
        end else begin
            n_rs = '0;
            n_ls = SH_W'(NRM_W - 1) - n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_vld <= 1'b0;
        else          r_c_vld <= r_b_vld;
    end

    always_ff @(posedge i_clk) begin
        r_c_rs   <= n_rs;
        r_c_ls   <= n_ls;
        r_c_zero <= (r_b_max == '0);
        r_c_mag  <= r_b_mag;
        r_c_neg  <= r_b_neg;
    end

    // stage D: apply the common shift
    logic       r_d_vld;
    t_norm_side r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_vld <= 1'b0;
        else          r_d_vld <= r_c_vld;
    end

    always_ff @(posedge i_clk) begin
        r_d_side.zero <= r_c_zero;
        r_d_side.neg  <= r_c_neg;
        for (int i = 0; i < 3; i++) begin
            r_d_side.mag[i] <= NRM_W'((r_c_mag[i] >> r_c_rs) << r_c_ls);
        end
    end

    // stage E: squares
    logic            r_e_vld;
    t_norm_side      r_e_side;
    logic [SQ_W-1:0] r_e_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_vld <= 1'b0;
        else          r_e_vld <= r_d_vld;
    end

    always_ff @(posedge i_clk) begin
        r_e_side <= r_d_side;
        for (int i = 0; i < 3; i++) begin
            r_e_sq[i] <= SQ_W'(r_d_side.mag[i]) * SQ_W'(r_d_side.mag[i]);
        end
    end

    // stage F (root stage 0): sum of squares, then one root bit per stage
    logic              r_s_vld  [ROOT_W+1];
    t_norm_side        r_s_side [ROOT_W+1];
    logic [SUM_W-1:0]  r_s_rad  [ROOT_W+1];
    logic [REM_W-1:0]  r_s_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_s_root [ROOT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s_vld[0] <= 1'b0;
        else          r_s_vld[0] <= r_e_vld;
    end

    always_ff @(posedge i_clk) begin
        r_s_side[0] <= r_e_side;
        r_s_rad[0]  <= SUM_W'(r_e_sq[0]) + SUM_W'(r_e_sq[1]) + SUM_W'(r_e_sq[2]);
        r_s_rem[0]  <= '0;
        r_s_root[0] <= '0;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        localparam int B = ROOT_W - 1 - k;
        logic [REM_W+1:0] w_try;
        logic [REM_W+1:0] w_trial;

        assign w_try   = {r_s_rem[k], r_s_rad[k][2*B+1 -: 2]};
        assign w_trial = (REM_W + 2)'({r_s_root[k], 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_s_vld[k+1] <= 1'b0;
            else          r_s_vld[k+1] <= r_s_vld[k];
        end

        always_ff @(posedge i_clk) begin
            r_s_side[k+1] <= r_s_side[k];
            r_s_rad[k+1]  <= r_s_rad[k];
            if (w_try >= w_trial) begin
                r_s_rem[k+1]  <= REM_W'(w_try - w_trial);
                r_s_root[k+1] <= {r_s_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                r_s_rem[k+1]  <= REM_W'(w_try);
                r_s_root[k+1] <= {r_s_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // stage G (divide stage 0): rounded numerators
    logic              r_v_vld  [Q_W+1];
    logic              r_v_zero [Q_W+1];
    logic [2:0]        r_v_neg  [Q_W+1];
    logic [ROOT_W-1:0] r_v_len  [Q_W+1];
    logic [ROOT_W-1:0] r_v_rem  [Q_W+1][3];
    logic [Q_W-1:0]    r_v_low  [Q_W+1][3];
    logic [NUM_W-1:0]  n_num    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = (NUM_W'(r_s_side[ROOT_W].mag[i]) << FRAC_BITS)
                     + NUM_W'(r_s_root[ROOT_W] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v_vld[0] <= 1'b0;
        else          r_v_vld[0] <= r_s_vld[ROOT_W];
    end

    always_ff @(posedge i_clk) begin
        r_v_zero[0] <= r_s_side[ROOT_W].zero;
        r_v_neg[0]  <= r_s_side[ROOT_W].neg;
        r_v_len[0]  <= r_s_root[ROOT_W];
        for (int i = 0; i < 3; i++) begin
            r_v_rem[0][i] <= ROOT_W'(n_num[i] >> Q_W);
            r_v_low[0][i] <= n_num[i][Q_W-1:0];
        end
    end

    // one quotient bit per stage; dividend bits leave the top of low as
    // quotient bits enter at the bottom
    for (genvar k = 0; k < Q_W; k++) begin : g_div
        logic [ROOT_W:0] w_try [3];
        logic            w_ge  [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_try[i] = {r_v_rem[k][i], r_v_low[k][i][Q_W-1]};
                w_ge[i]  = (w_try[i] >= {1'b0, r_v_len[k]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v_vld[k+1] <= 1'b0;
            else          r_v_vld[k+1] <= r_v_vld[k];
        end

        always_ff @(posedge i_clk) begin
            r_v_zero[k+1] <= r_v_zero[k];
            r_v_neg[k+1]  <= r_v_neg[k];
            r_v_len[k+1]  <= r_v_len[k];
            for (int i = 0; i < 3; i++) begin
                r_v_rem[k+1][i] <= w_ge[i] ? ROOT_W'(w_try[i] - {1'b0, r_v_len[k]})
                                           : ROOT_W'(w_try[i]);
                r_v_low[k+1][i] <= {r_v_low[k][i][Q_W-2:0], w_ge[i]};
            end
        end
    end

    // stage H: sign, saturate, force zero vectors to zero
    logic              r_h_vld;
    logic              r_h_zero;
    t_unit             r_h_unit [3];
    logic signed [SAT_W-1:0] n_sv [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sv[i] = $signed(SAT_W'(r_v_low[Q_W][i]));
            if (r_v_neg[Q_W][i]) n_sv[i] = -n_sv[i];
            if (n_sv[i] > SAT_W'(OUT_MAX)) n_sv[i] = SAT_W'(OUT_MAX);
            if (n_sv[i] < SAT_W'(OUT_MIN)) n_sv[i] = SAT_W'(OUT_MIN);
            if (r_v_zero[Q_W]) n_sv[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h_vld <= 1'b0;
        else          r_h_vld <= r_v_vld[Q_W];
    end

    always_ff @(posedge i_clk) begin
        r_h_zero <= r_v_zero[Q_W];
        for (int i = 0; i < 3; i++) begin
            r_h_unit[i] <= OUT_W'(n_sv[i]);
        end
    end

    assign o_valid = r_h_vld;
    assign o_zero  = r_h_zero;
    assign o_unit  = r_h_unit;

endmodule

// ===== hw/rtl/frenet_start_frame_core.sv =====
// ----------------------------------------------------------------------------
// frenet_start_frame_core: Frenet frame of a cylindrical curve
// Builds three points from radius/height samples at angles 0, h, 2h, takes
// first and second differences, scales both to unit length and crosses them.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+-----------------------
//  request   | i_radius_at_step0..2, i_height_..0..2  | start high, busy low
//  result    | o_tangent_*, o_normal_*, o_binormal_*, | o_valid, one cycle,
//            | o_degenerate                           | no back-pressure
//  config    | i_cfg_idx, i_cfg_data                  | i_cfg_we, one cycle
//
//  A request enters every cycle; busy is never raised. After acceptance a
//  result passes 3 front stages (multiply, round, difference), 56 in the
//  normalizer (6 setup, 31 square-root bits, 1 numerator, 17 quotient bits,
//  1 sign) and 2 for the cross product.
//  Reset clears the valid chain and the trig registers (cos 1.0, sin 0).
//  Results cannot be held off, so nothing in the pipe ever stalls.
//
module frenet_start_frame_core
    import fsf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    start,
    output logic                    busy,
    input  logic signed [IN_W-1:0]  i_radius_at_step0,
    input  logic signed [IN_W-1:0]  i_radius_at_step1,
    input  logic signed [IN_W-1:0]  i_radius_at_step2,
    input  logic signed [IN_W-1:0]  i_height_at_step0,
    input  logic signed [IN_W-1:0]  i_height_at_step1,
    input  logic signed [IN_W-1:0]  i_height_at_step2,

    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,

    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_tangent_x,
    output logic signed [OUT_W-1:0] o_tangent_y,
    output logic signed [OUT_W-1:0] o_tangent_z,
    output logic signed [OUT_W-1:0] o_normal_x,
    output logic signed [OUT_W-1:0] o_normal_y,
    output logic signed [OUT_W-1:0] o_normal_z,
    output logic signed [OUT_W-1:0] o_binormal_x,
    output logic signed [OUT_W-1:0] o_binormal_y,
    output logic signed [OUT_W-1:0] o_binormal_z,
    output logic [1:0]              o_degenerate
);

    // round a product to FRAC_BITS, ties away from zero
    function automatic logic signed [PT_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] sh;
        mag = p[PROD_W-1] ? $unsigned(-p) : $unsigned(p);
        sh  = (mag + HALF) >> FRAC_BITS;
        return p[PROD_W-1] ? -$signed(PT_W'(sh)) : $signed(PT_W'(sh));
    endfunction

    // round a cross-product term to FRAC_BITS, ties away, then saturate
    function automatic t_unit round_cross(input logic signed [XD_W-1:0] e);
        logic [XD_W-1:0]         mag;
        logic [XD_W-1:0]         sh;
        logic signed [XD_W-1:0]  r;
        mag = e[XD_W-1] ? $unsigned(-e) : $unsigned(e);
        sh  = (mag + XD_W'(HALF)) >> FRAC_BITS;
        r   = e[XD_W-1] ? -$signed(sh) : $signed(sh);
        if (r > XD_W'(OUT_MAX)) r = XD_W'(OUT_MAX);
        if (r < XD_W'(OUT_MIN)) r = XD_W'(OUT_MIN);
        return OUT_W'(r);
    endfunction

    // every cycle is open for a request
    assign busy = 1'b0;

    // ---------------- configuration registers ----------------
    logic signed [CFG_W-1:0] r_cos_one;
    logic signed [CFG_W-1:0] r_sin_one;
    logic signed [CFG_W-1:0] r_cos_two;
    logic signed [CFG_W-1:0] r_sin_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_one <= CFG_W'(1 << FRAC_BITS);
            r_sin_one <= '0;
            r_cos_two <= CFG_W'(1 << FRAC_BITS);
            r_sin_two <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COS_ONE: r_cos_one <= i_cfg_data;
                REG_SIN_ONE: r_sin_one <= i_cfg_data;
                REG_COS_TWO: r_cos_two <= i_cfg_data;
                REG_SIN_TWO: r_sin_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: radius times trig ----------------
    logic                     r_s1_vld;
    logic signed [PROD_W-1:0] r_s1_m1x, r_s1_m1y, r_s1_m2x, r_s1_m2y;
    logic signed [IN_W-1:0]   r_s1_r0, r_s1_z0, r_s1_z1, r_s1_z2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_vld <= 1'b0;
        else          r_s1_vld <= start && !busy;
    end

    always_ff @(posedge i_clk) begin
        r_s1_m1x <= PROD_W'(i_radius_at_step1) * PROD_W'(r_cos_one);
        r_s1_m1y <= PROD_W'(i_radius_at_step1) * PROD_W'(r_sin_one);
        r_s1_m2x <= PROD_W'(i_radius_at_step2) * PROD_W'(r_cos_two);
        r_s1_m2y <= PROD_W'(i_radius_at_step2) * PROD_W'(r_sin_two);
        r_s1_r0  <= i_radius_at_step0;
        r_s1_z0  <= i_height_at_step0;
        r_s1_z1  <= i_height_at_step1;
        r_s1_z2  <= i_height_at_step2;
    end

    // ---------------- stage 2: round the products ----------------
    logic                   r_s2_vld;
    logic signed [PT_W-1:0] r_s2_p1x, r_s2_p1y, r_s2_p2x, r_s2_p2y;
    logic signed [IN_W-1:0] r_s2_r0, r_s2_z0, r_s2_z1, r_s2_z2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_vld <= 1'b0;
        else          r_s2_vld <= r_s1_vld;
    end

    always_ff @(posedge i_clk) begin
        r_s2_p1x <= round_prod(r_s1_m1x);
        r_s2_p1y <= round_prod(r_s1_m1y);
        r_s2_p2x <= round_prod(r_s1_m2x);
        r_s2_p2y <= round_prod(r_s1_m2y);
        r_s2_r0  <= r_s1_r0;
        r_s2_z0  <= r_s1_z0;
        r_s2_z1  <= r_s1_z1;
        r_s2_z2  <= r_s1_z2;
    end

    // ---------------- stage 3: first and second differences ----------------
    logic r_s3_vld;
    t_vec r_s3_t [3];
    t_vec r_s3_n [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_vld <= 1'b0;
        else          r_s3_vld <= r_s2_vld;
    end

    always_ff @(posedge i_clk) begin
        r_s3_t[0] <= VEC_W'(r_s2_p1x) - VEC_W'(r_s2_r0);
        r_s3_t[1] <= VEC_W'(r_s2_p1y);
        r_s3_t[2] <= VEC_W'(r_s2_z1) - VEC_W'(r_s2_z0);
        r_s3_n[0] <= VEC_W'(r_s2_r0) - (VEC_W'(r_s2_p1x) <<< 1) + VEC_W'(r_s2_p2x);
        r_s3_n[1] <= VEC_W'(r_s2_p2y) - (VEC_W'(r_s2_p1y) <<< 1);
        r_s3_n[2] <= VEC_W'(r_s2_z0) - (VEC_W'(r_s2_z1) <<< 1) + VEC_W'(r_s2_z2);
    end

    // ---------------- normalizers, one per vector ----------------
    logic  w_tan_vld, w_nrm_vld, w_tan_zero, w_nrm_zero;
    t_unit w_tu [3];
    t_unit w_nu [3];

    fsf_unit3 u_tan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_vld),
        .i_vec   (r_s3_t),
        .o_valid (w_tan_vld),
        .o_unit  (w_tu),
        .o_zero  (w_tan_zero)
    );

    fsf_unit3 u_nrm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_vld),
        .i_vec   (r_s3_n),
        .o_valid (w_nrm_vld),
        .o_unit  (w_nu),
        .o_zero  (w_nrm_zero)
    );

    // ---------------- stage 4: cross-product terms ----------------
    logic                   r_s4_vld;
    logic signed [XP_W-1:0] r_s4_yz, r_s4_zy, r_s4_zx, r_s4_xz, r_s4_xy, r_s4_yx;
    t_unit                  r_s4_tu [3];
    t_unit                  r_s4_nu [3];
    logic [1:0]             r_s4_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s4_vld <= 1'b0;
        else          r_s4_vld <= w_tan_vld && w_nrm_vld;
    end

    always_ff @(posedge i_clk) begin
        r_s4_yz  <= XP_W'(w_tu[1]) * XP_W'(w_nu[2]);
        r_s4_zy  <= XP_W'(w_tu[2]) * XP_W'(w_nu[1]);
        r_s4_zx  <= XP_W'(w_tu[2]) * XP_W'(w_nu[0]);
        r_s4_xz  <= XP_W'(w_tu[0]) * XP_W'(w_nu[2]);
        r_s4_xy  <= XP_W'(w_tu[0]) * XP_W'(w_nu[1]);
        r_s4_yx  <= XP_W'(w_tu[1]) * XP_W'(w_nu[0]);
        r_s4_tu  <= w_tu;
        r_s4_nu  <= w_nu;
        r_s4_deg <= {w_nrm_zero, w_tan_zero};
    end

    // ---------------- stage 5: binormal and output registers ----------------
    // take the difference on exact products, round once at the end
    logic       r_s5_vld;
    t_unit      r_s5_tu [3];
    t_unit      r_s5_nu [3];
    t_unit      r_s5_bn [3];
    logic [1:0] r_s5_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s5_vld <= 1'b0;
        else          r_s5_vld <= r_s4_vld;
    end

    always_ff @(posedge i_clk) begin
        r_s5_bn[0] <= round_cross(XD_W'(r_s4_yz) - XD_W'(r_s4_zy));
        r_s5_bn[1] <= round_cross(XD_W'(r_s4_zx) - XD_W'(r_s4_xz));
        r_s5_bn[2] <= round_cross(XD_W'(r_s4_xy) - XD_W'(r_s4_yx));
        r_s5_tu    <= r_s4_tu;
        r_s5_nu    <= r_s4_nu;
        r_s5_deg   <= r_s4_deg;
    end

    assign o_valid      = r_s5_vld;
    assign o_tangent_x  = r_s5_tu[0];
    assign o_tangent_y  = r_s5_tu[1];
    assign o_tangent_z  = r_s5_tu[2];
    assign o_normal_x   = r_s5_nu[0];
    assign o_normal_y   = r_s5_nu[1];
    assign o_normal_z   = r_s5_nu[2];
    assign o_binormal_x = r_s5_bn[0];
    assign o_binormal_y = r_s5_bn[1];
    assign o_binormal_z = r_s5_bn[2];
    assign o_degenerate = r_s5_deg;

endmodule
